// ----- hw/rtl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

  // queue depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_EMPTY = 2'd1;
  localparam logic [1:0] FAULT_FULL  = 2'd2;

  // per-cell control from the top level
  typedef struct packed {
    logic load;      // update the cell this cycle
    logic insert;    // 1 = insert, 0 = remove
    logic occupied;  // cell holds a stored entry
    logic at_tail;   // cell is the first free slot
  } spq_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_core.sv -----
// sorted min-priority queue: chain of compare-and-shift cells
// latency: a result is valid the cycle after its input transfer
// throughput: one item per cycle while out_ready stays high
// each operation touches all cells in parallel
// reset clears the fill count and the result valid flag; entry storage is not reset
`default_nettype none

module sorted_priority_queue_core (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire             action,
  input  spq_pkg::data_t  item_value,
  input  spq_pkg::data_t  priority_req,
  output logic            out_valid,
  input  wire             out_ready,
  output spq_pkg::data_t  removed_item,
  output spq_pkg::data_t  head_item,
  output spq_pkg::data_t  head_priority,
  output spq_pkg::cnt_t   count,
  output logic            is_empty,
  output logic [1:0]      fault
);
  import spq_pkg::*;

  cnt_t       fill_count;
  cnt_t       fill_count_next;
  logic       xfer;
  logic       is_insert;
  logic [1:0] fault_next;
  logic       do_op;

  data_t cell_item [CAPACITY];
  data_t cell_prio [CAPACITY];
  logic  cell_gt   [CAPACITY];
  data_t d_item    [CAPACITY];
  data_t d_prio    [CAPACITY];

  // input side stalls only while a result waits
  assign in_ready  = !out_valid || out_ready;
  assign xfer      = in_valid && in_ready;
  assign is_insert = (action == ACT_INSERT);

  // fault detection and next fill count
  always_comb begin
    fault_next      = FAULT_NONE;
    fill_count_next = fill_count;
    if (is_insert) begin
      if (fill_count == cnt_t'(CAPACITY)) begin
        fault_next = FAULT_FULL;
      end else begin
        fill_count_next = fill_count + cnt_t'(1);
      end
    end else begin
      if (fill_count == '0) begin
        fault_next = FAULT_EMPTY;
      end else begin
        fill_count_next = fill_count - cnt_t'(1);
      end
    end
  end

  assign do_op = xfer && (fault_next == FAULT_NONE);

  // cell chain
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    spq_ctrl_t ctrl;
    data_t     p_item;
    data_t     p_prio;
    logic      p_gt;
    data_t     n_item;
    data_t     n_prio;

    assign ctrl.load     = do_op;
    assign ctrl.insert   = is_insert;
    assign ctrl.occupied = cnt_t'(k) < fill_count;
    assign ctrl.at_tail  = cnt_t'(k) == fill_count;

    if (k == 0) begin : g_first
      assign p_item = item_value;
      assign p_prio = priority_req;
      assign p_gt   = 1'b0;
    end else begin : g_mid
      assign p_item = cell_item[k-1];
      assign p_prio = cell_prio[k-1];
      assign p_gt   = cell_gt[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign n_item = '0;
      assign n_prio = '0;
    end else begin : g_inner
      assign n_item = cell_item[k+1];
      assign n_prio = cell_prio[k+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_item  (item_value),
      .new_prio  (priority_req),
      .prev_item (p_item),
      .prev_prio (p_prio),
      .prev_gt   (p_gt),
      .next_item (n_item),
      .next_prio (n_prio),
      .cell_item (cell_item[k]),
      .cell_prio (cell_prio[k]),
      .cell_gt   (cell_gt[k]),
      .d_item    (d_item[k]),
      .d_prio    (d_prio[k])
    );
  end

  // fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (do_op) begin
        fill_count <= fill_count_next;
      end
      if (xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (xfer) begin
      fault    <= fault_next;
      count    <= fill_count_next;
      is_empty <= (fill_count_next == '0);
      removed_item <= (!is_insert && fault_next == FAULT_NONE) ? cell_item[0] : '0;
      if (fill_count_next == '0) begin
        head_item     <= '0;
        head_priority <= '0;
      end else if (fault_next == FAULT_NONE) begin
        head_item     <= d_item[0];
        head_priority <= d_prio[0];
      end else begin
        head_item     <= cell_item[0];
        head_priority <= cell_prio[0];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    fill_count <= cnt_t'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (xfer && is_insert && fill_count != cnt_t'(CAPACITY))
      |=> (fill_count == $past(fill_count) + cnt_t'(1)))
    else $error("insert did not grow the queue");

  a_empty_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_fault_empty : assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault == FAULT_EMPTY) |-> (removed_item == '0 && is_empty))
    else $error("remove from empty queue returned data");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// one compare-and-shift cell of the sorted queue chain
`default_nettype none

module spq_cell (
  input  wire               clk,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  spq_pkg::data_t    new_item,
  input  spq_pkg::data_t    new_prio,
  input  spq_pkg::data_t    prev_item,
  input  spq_pkg::data_t    prev_prio,
  input  wire               prev_gt,
  input  spq_pkg::data_t    next_item,
  input  spq_pkg::data_t    next_prio,
  output spq_pkg::data_t    cell_item,
  output spq_pkg::data_t    cell_prio,
  output logic              cell_gt,
  output spq_pkg::data_t    d_item,
  output spq_pkg::data_t    d_prio
);
  import spq_pkg::*;

  data_t item;
  data_t prio;

  // new entry goes ahead of this one only on a strictly lower priority
  assign cell_gt   = ctrl.occupied && (new_prio < prio);
  assign cell_item = item;
  assign cell_prio = prio;

  // pick the next value: shift down, take the new entry, shift up or hold
  always_comb begin
    d_item = item;
    d_prio = prio;
    if (ctrl.insert) begin
      if (prev_gt) begin
        d_item = prev_item;
        d_prio = prev_prio;
      end else if (cell_gt || ctrl.at_tail) begin
        d_item = new_item;
        d_prio = new_prio;
      end
    end else begin
      d_item = next_item;
      d_prio = next_prio;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item <= d_item;
      prio <= d_prio;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the sorted min-priority queue core: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_ITEMS   = 50;
  localparam int NUM_PHASES    = 9;
  localparam int DIR_ROWS      = 23;
  localparam int IDLE_PCT      = 18;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    data_t      removed;
    data_t      head_item;
    data_t      head_prio;
    cnt_t       count;
    logic       empty;
    logic [1:0] fault;
  } queue_result_t;

  typedef struct packed {
    logic          act;
    data_t         item;
    data_t         prio;
    logic          typed;
    queue_result_t want;
  } stim_row_t;

  localparam queue_result_t NO_CHECK = '0;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic       action       = ACT_INSERT;
  data_t      item_value   = '0;
  data_t      priority_req = '0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  data_t      removed_item;
  data_t      head_item;
  data_t      head_priority;
  cnt_t       count;
  logic       is_empty;
  logic [1:0] fault;

  sorted_priority_queue_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .item_value   (item_value),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .removed_item (removed_item),
    .head_item    (head_item),
    .head_priority(head_priority),
    .count        (count),
    .is_empty     (is_empty),
    .fault        (fault)
  );

  // queue model state
  data_t model_items [CAPACITY];
  data_t model_prios [CAPACITY];
  int    model_fill = 0;

  // scoreboard and bookkeeping
  queue_result_t pending_results [$];
  queue_result_t oldest;
  int  mismatches    = 0;
  int  transfers_in  = 0;
  int  results_seen  = 0;
  int  full_drops    = 0;
  int  empty_removes = 0;
  int  peak_fill     = 0;
  int  cycle_count   = 0;
  int  hold_requests = 0;
  int  hold_served   = 0;
  bit  quiet         = 1'b0;

  // sorted insert / front remove, one result per operation
  function automatic queue_result_t apply_queue_op(logic act, data_t item, data_t prio);
    queue_result_t res;
    int pos;
    res = '0;
    res.fault = FAULT_NONE;
    if (act == ACT_INSERT) begin
      if (model_fill >= CAPACITY) begin
        res.fault = FAULT_FULL;
        full_drops++;
      end else begin
        // new entry goes after every entry of equal priority
        pos = model_fill;
        while (pos > 0 && prio < model_prios[pos-1]) pos--;
        for (int k = model_fill; k > pos; k--) begin
          model_items[k] = model_items[k-1];
          model_prios[k] = model_prios[k-1];
        end
        model_items[pos] = item;
        model_prios[pos] = prio;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        res.fault = FAULT_EMPTY;
        empty_removes++;
      end else begin
        res.removed = model_items[0];
        for (int k = 1; k < model_fill; k++) begin
          model_items[k-1] = model_items[k];
          model_prios[k-1] = model_prios[k];
        end
        model_fill--;
      end
    end
    if (model_fill > 0) begin
      res.head_item = model_items[0];
      res.head_prio = model_prios[0];
    end
    res.count = cnt_t'(model_fill);
    res.empty = (model_fill == 0);
    if (model_fill > peak_fill) peak_fill = model_fill;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH at result %0d, %s: got %h, wanted %h", results_seen, what, got, want);
    mismatches++;
  endtask

  // one input transfer, expectation queued when it is accepted
  task automatic send_item(input logic act, input data_t item, input data_t prio,
                           input logic typed, input queue_result_t typed_res);
    queue_result_t predicted;
    in_valid     <= 1'b1;
    action       <= act;
    item_value   <= item;
    priority_req <= prio;
    do @(posedge clk); while (!in_ready);
    predicted = apply_queue_op(act, item, prio);
    pending_results.push_back(typed ? typed_res : predicted);
    transfers_in++;
  endtask

  // random gap on the input side
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic data_t pick_priority();
    data_t p;
    case ($urandom_range(0, 3))
      0, 1: p = data_t'($urandom_range(0, 6)) - data_t'(3);
      2: begin
        case ($urandom_range(0, 3))
          0: p = 32'h8000_0000;
          1: p = 32'h7FFF_FFFF;
          2: p = 32'h0000_0000;
          default: p = 32'hFFFF_FFFF;
        endcase
      end
      default: p = data_t'($urandom);
    endcase
    return p;
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", removed_item, 32'h0);
      end else begin
        oldest = pending_results.pop_front();
        if (removed_item !== oldest.removed)
          report_mismatch("removed_item", removed_item, oldest.removed);
        if (head_item !== oldest.head_item)
          report_mismatch("head_item", head_item, oldest.head_item);
        if (head_priority !== oldest.head_prio)
          report_mismatch("head_priority", head_priority, oldest.head_prio);
        if (count !== oldest.count)
          report_mismatch("count", 32'(count), 32'(oldest.count));
        if (is_empty !== oldest.empty)
          report_mismatch("is_empty", 32'(is_empty), 32'(oldest.empty));
        if (fault !== oldest.fault)
          report_mismatch("fault", 32'(fault), 32'(oldest.fault));
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t dir_table [DIR_ROWS];
    int insert_pct [NUM_PHASES];
    data_t rnd_item;
    logic  rnd_act;

    // directed table: extremes, ties, full and empty cases
    dir_table[0]  = '{ACT_REMOVE, 32'h0, 32'h0, 1'b1,
                      '{32'h0, 32'h0, 32'h0, 5'd0, 1'b1, FAULT_EMPTY}};
    dir_table[1]  = '{ACT_INSERT, 32'h7FFF_FFFF, 32'h0, 1'b1,
                      '{32'h0, 32'h7FFF_FFFF, 32'h0, 5'd1, 1'b0, FAULT_NONE}};
    dir_table[2]  = '{ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_CHECK};
    dir_table[3]  = '{ACT_INSERT, 32'h1, 32'h8000_0000, 1'b1,
                      '{32'h0, 32'h1, 32'h8000_0000, 5'd3, 1'b0, FAULT_NONE}};
    dir_table[4]  = '{ACT_INSERT, 32'h2, 32'h0, 1'b0, NO_CHECK};
    dir_table[5]  = '{ACT_INSERT, 32'h3, 32'h0, 1'b0, NO_CHECK};
    dir_table[6]  = '{ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_CHECK};
    dir_table[7]  = '{ACT_INSERT, 32'h5555_5555, 32'h7FFF_FFFF, 1'b0, NO_CHECK};
    dir_table[8]  = '{ACT_INSERT, 32'hAAAA_AAAA, 32'h8000_0000, 1'b0, NO_CHECK};
    dir_table[9]  = '{ACT_INSERT, 32'd10, 32'd5, 1'b0, NO_CHECK};
    dir_table[10] = '{ACT_INSERT, 32'd11, 32'd5, 1'b0, NO_CHECK};
    dir_table[11] = '{ACT_INSERT, 32'd12, 32'hFFFF_FFFB, 1'b0, NO_CHECK};
    dir_table[12] = '{ACT_INSERT, 32'd13, 32'd100, 1'b0, NO_CHECK};
    dir_table[13] = '{ACT_INSERT, 32'd14, 32'h7FFF_FFFF, 1'b0, NO_CHECK};
    dir_table[14] = '{ACT_INSERT, 32'd15, 32'd0, 1'b0, NO_CHECK};
    dir_table[15] = '{ACT_INSERT, 32'd16, 32'd1, 1'b0, NO_CHECK};
    dir_table[16] = '{ACT_INSERT, 32'd17, 32'd2, 1'b0, NO_CHECK};
    // queue is full here, the next insert is dropped
    dir_table[17] = '{ACT_INSERT, 32'd99, 32'hFFFF_FF9C, 1'b1,
                      '{32'h0, 32'h1, 32'h8000_0000, 5'd16, 1'b0, FAULT_FULL}};
    // remove with junk payload, tie at minimum priority keeps arrival order
    dir_table[18] = '{ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                      '{32'h1, 32'hAAAA_AAAA, 32'h8000_0000, 5'd15, 1'b0, FAULT_NONE}};
    dir_table[19] = '{ACT_REMOVE, 32'h0, 32'h0, 1'b0, NO_CHECK};
    dir_table[20] = '{ACT_REMOVE, 32'h1234_5678, 32'h8765_4321, 1'b0, NO_CHECK};
    dir_table[21] = '{ACT_INSERT, 32'h0, 32'h0, 1'b0, NO_CHECK};
    dir_table[22] = '{ACT_REMOVE, 32'h0, 32'h0, 1'b0, NO_CHECK};

    // insert share per random phase: fill-heavy, drain-heavy and balanced in turn
    insert_pct = '{85, 15, 60, 95, 10, 50, 90, 20, 50};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      maybe_idle();
      send_item(dir_table[i].act, dir_table[i].item, dir_table[i].prio,
                dir_table[i].typed, dir_table[i].want);
    end

    // pause until every result of the directed part is back
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = (p == 2);
      // long receiver hold-off while items keep coming
      if (p == 4) hold_requests++;
      // sender waits for a full drain before this phase
      if (p == 6) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        maybe_idle();
        rnd_act  = ($urandom_range(0, 99) < insert_pct[p]) ? ACT_INSERT : ACT_REMOVE;
        rnd_item = data_t'($urandom);
        send_item(rnd_act, rnd_item, pick_priority(), 1'b0, NO_CHECK);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain, then keep the clock running for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d transfers in and %0d results out, deepest fill %0d",
             transfers_in, results_seen, peak_fill);
    $display("inserts dropped at full: %0d, removes on empty: %0d, mismatches: %0d",
             full_drops, empty_removes, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
sim/tb.sv
